### rtl/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

   // field widths of the request and response words
   localparam int OPCODE_W   = 2;
   localparam int POSITION_W = 8;
   localparam int LENGTH_W   = 9;
   localparam int STATUS_W   = 2;
   localparam int CSR_W      = 9;

   // reset value of the valid-size register
   localparam logic [CSR_W-1:0] BITS_IN_USE_RESET = 9'd256;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_TEST  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SET   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_FIND  = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [POSITION_W-1:0] position;
      logic [LENGTH_W-1:0]   run_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [POSITION_W-1:0] found_start;
      logic                  bit_value;
   } rsp_type;

endpackage

### rtl/bitmap_first_fit_allocator_unit.sv
`timescale 1ns / 1ps
// an out-of-range test/set/clear or a zero-length find is answered from a register in the cycle
//   after start; every other request turns the ring and is answered at its last step
// a scanning request turns the ring of bitmap cells once past the head cell, then the unit
//   returns to idle; busy is high while the ring turns and no new request is taken then
// reset: synchronous, clears the bitmap to all free and sets bits_in_use to 256
// the receiver cannot stall: each response word is shown for exactly one cycle

module bitmap_first_fit_allocator_unit
   import bfa_pkg::*;
#(
   parameter int MAP_BITS = 256
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(MAP_BITS);
   localparam int CMP_W = (CNT_W + 1 > 10) ? CNT_W + 1 : 10;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [OPCODE_W-1:0]    op_ff;
   logic [CMP_W-1:0]       pos_ff;
   logic [CMP_W-1:0]       end_ff;
   logic [CMP_W-1:0]       len_ff;
   logic [CMP_W-1:0]       size_ff;
   logic [CMP_W-1:0]       run_ff;
   logic                   hit_ff;
   logic [POSITION_W-1:0]  start_ff;
   logic                   tbit_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   logic [CSR_W-1:0]       bits_in_use_ff;

   logic [MAP_BITS-1:0]    ring_q;
   logic                   shift_en;
   logic                   head;
   logic                   tail_val;

   logic [CMP_W-1:0]       size_now;
   logic [CMP_W-1:0]       req_pos;
   logic [CMP_W-1:0]       req_len;
   logic                   imm_range;
   logic                   imm_notfound;
   logic [CMP_W-1:0]       cnt_ext;
   logic                   in_range;
   logic                   find_active;
   logic [CMP_W-1:0]       run_in;
   logic                   hit_now;
   logic [CMP_W-1:0]       start_now;
   logic                   last_step;
   rsp_type                scan_rsp;

   // ring of bitmap cells, cell 0 is the head
   for (genvar k = 0; k < MAP_BITS; k++) begin : g_cell
      logic nxt;
      if (k == MAP_BITS - 1) begin : g_tail
         assign nxt = tail_val;
      end else begin : g_mid
         assign nxt = ring_q[k+1];
      end
      bfa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_in (nxt),
         .bit_q    (ring_q[k])
      );
   end

   assign shift_en = (state_ff == S_SCAN);
   assign head     = ring_q[0];

   // request checks against the valid size
   always_comb begin
      size_now = (CMP_W'(bits_in_use_ff) > CMP_W'(MAP_BITS)) ? CMP_W'(MAP_BITS)
                                                               : CMP_W'(bits_in_use_ff);
      req_pos  = CMP_W'(req_data.position);
      req_len  = CMP_W'(req_data.run_length);
      imm_range    = ((req_data.opcode == OP_TEST) && (req_pos >= size_now)) ||
                     ((req_data.opcode == OP_SET || req_data.opcode == OP_CLEAR) &&
                      (req_pos + req_len > size_now));
      imm_notfound = (req_data.opcode == OP_FIND) && (req_len == '0);
   end

   // per-step work on the head cell
   always_comb begin
      cnt_ext     = CMP_W'(cnt_ff);
      in_range    = (cnt_ext >= pos_ff) && (cnt_ext < end_ff);
      tail_val    = head;
      if ((op_ff == OP_SET || op_ff == OP_CLEAR) && in_range) begin
         tail_val = (op_ff == OP_SET);
      end
      find_active = (op_ff == OP_FIND) && !hit_ff && (cnt_ext < size_ff);
      run_in      = head ? '0 : run_ff + CMP_W'(1);
      hit_now     = find_active && (run_in == len_ff);
      start_now   = cnt_ext + CMP_W'(1) - len_ff;
      last_step   = (cnt_ff == CNT_W'(MAP_BITS - 1));
      // response word at the end of a scan
      scan_rsp    = '{status: ST_OK, found_start: '0, bit_value: 1'b0};
      if (op_ff == OP_FIND) begin
         if (hit_ff) begin
            scan_rsp.found_start = start_ff;
         end else if (hit_now) begin
            scan_rsp.found_start = start_now[POSITION_W-1:0];
         end else begin
            scan_rsp.status = ST_NOTFOUND;
         end
      end else if (op_ff == OP_TEST) begin
         scan_rsp.bit_value = (cnt_ext == pos_ff) ? head : tbit_ff;
      end
   end

   // control, scan bookkeeping and the response word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         bits_in_use_ff <= BITS_IN_USE_RESET;
         cnt_ff         <= '0;
         hit_ff         <= 1'b0;
         run_ff         <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            bits_in_use_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= start && (imm_range || imm_notfound);
               if (start) begin
                  op_ff   <= req_data.opcode;
                  pos_ff  <= req_pos;
                  end_ff  <= req_pos + req_len;
                  len_ff  <= req_len;
                  size_ff <= size_now;
                  cnt_ff  <= '0;
                  run_ff  <= '0;
                  hit_ff  <= 1'b0;
                  tbit_ff <= 1'b0;
                  if (imm_range) begin
                     rsp_ff <= '{status: ST_RANGE, found_start: '0, bit_value: 1'b0};
                  end else if (imm_notfound) begin
                     rsp_ff <= '{status: ST_NOTFOUND, found_start: '0, bit_value: 1'b0};
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               rsp_valid_ff <= last_step;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (find_active) begin
                  run_ff <= run_in;
               end
               if (hit_now) begin
                  hit_ff   <= 1'b1;
                  start_ff <= start_now[POSITION_W-1:0];
               end
               if (op_ff == OP_TEST && cnt_ext == pos_ff) begin
                  tbit_ff <= head;
               end
               if (last_step) begin
                  state_ff <= S_IDLE;
                  rsp_ff   <= scan_rsp;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = (state_ff == S_SCAN);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a response never overlaps a turning ring
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while scanning");

   // every accepted word starts a scan or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither scanned nor answered");

   // the end of a scan always yields a response
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("scan ended without a response");

   // a failed find reports no start
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NOTFOUND) |-> (rsp_data.found_start == '0))
      else $error("not-found response with nonzero start");

endmodule

### rtl/bfa_cell.sv
`timescale 1ns / 1ps

module bfa_cell
   import bfa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  logic shift_in,
   output logic bit_q
);

   logic bit_ff;
   logic bit_in;

   // take the neighbour's bit while the ring turns
   always_comb begin
      bit_in = shift_en ? shift_in : bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_q = bit_ff;

endmodule

### test/tb_bitmap_first_fit_allocator_unit.sv
`timescale 1ns / 1ps

module tb_bitmap_first_fit_allocator_unit
   import bfa_pkg::*;
;

   localparam int MAP_BITS     = 256;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_ITEMS = 84;

   // mirror of the allocation map and the size register, with the responses still owed
   class bitmap_tracker;
      bit [MAP_BITS-1:0] alloc_bits;
      int unsigned       size_reg;
      rsp_type           expected_rsp[$];
      int                mismatches;
      int                checked;
      int                noted;
      int                status_count[3];

      function new();
         alloc_bits = '0;
         size_reg   = 32'(BITS_IN_USE_RESET);
         mismatches = 0;
         checked    = 0;
         noted      = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function void load_size(logic [CSR_W-1:0] value);
         size_reg = 32'(value);
      endfunction

      // register values beyond the map are clipped to its length
      function int unsigned valid_size();
         return (size_reg > MAP_BITS) ? MAP_BITS : size_reg;
      endfunction

      // work out the response of an accepted request word and update the map
      function void note_request(req_type req);
         rsp_type     rsp;
         int unsigned size;
         int unsigned pos;
         int unsigned len;
         int unsigned run;
         bit          hit;
         size = valid_size();
         pos  = 32'(req.position);
         len  = 32'(req.run_length);
         rsp  = '0;
         rsp.status = ST_OK;
         if (req.opcode == OP_TEST) begin
            if (pos >= size) rsp.status = ST_RANGE;
            else rsp.bit_value = alloc_bits[pos];
         end else if (req.opcode == OP_SET || req.opcode == OP_CLEAR) begin
            if (pos + len > size) begin
               rsp.status = ST_RANGE;
            end else begin
               for (int unsigned i = pos; i < pos + len; i++)
                  alloc_bits[i] = (req.opcode == OP_SET);
            end
         end else begin
            // first-fit scan from the bottom of the map
            run = 0;
            hit = 1'b0;
            if (len != 0) begin
               for (int unsigned i = 0; i < size; i++) begin
                  if (!alloc_bits[i]) run++;
                  else run = 0;
                  if (run == len) begin
                     rsp.found_start = POSITION_W'(i + 1 - len);
                     hit = 1'b1;
                     break;
                  end
               end
            end
            if (!hit) rsp.status = ST_NOTFOUND;
         end
         status_count[rsp.status]++;
         noted++;
         expected_rsp.push_back(rsp);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      // compare one response word with the oldest one owed
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            flag($sformatf("response with nothing outstanding: status %0d start %0d bit %0d",
                           got.status, got.found_start, got.bit_value));
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         if (got.status !== want.status || got.found_start !== want.found_start ||
             got.bit_value !== want.bit_value)
            flag($sformatf({"response %0d wrong: expected status %0d start %0d bit %0d, ",
                            "got status %0d start %0d bit %0d"},
                           checked, want.status, want.found_start, want.bit_value,
                           got.status, got.found_start, got.bit_value));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data;

   bitmap_tracker tracker;
   int            cycle_count = 0;
   int            size_writes = 0;
   int            send_idle_pct;
   int unsigned   cur_size;
   int unsigned   size_plan[12];

   bitmap_first_fit_allocator_unit #(
      .MAP_BITS(MAP_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // sample handshakes at the rising edge, response first as it belongs to an older word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_response(rsp_data);
         if (start && !busy) tracker.note_request(req_data);
         if (csr_valid && csr_ready) begin
            tracker.load_size(csr_data);
            size_writes++;
         end
      end
   end

   function automatic req_type mk_req(logic [OPCODE_W-1:0] op, int unsigned pos,
                                      int unsigned len);
      req_type r;
      r.opcode     = op;
      r.position   = POSITION_W'(pos);
      r.run_length = LENGTH_W'(len);
      return r;
   endfunction

   // mostly in-range words with random content, the rest raw noise
   function automatic req_type random_req(int unsigned size);
      req_type     r;
      int unsigned room;
      int unsigned pos;
      int unsigned len;
      r.opcode = OPCODE_W'($urandom_range(3));
      pos      = $urandom_range(255);
      len      = $urandom_range(511);
      if ($urandom_range(99) < 80 && size > 0) begin
         pos = $urandom_range(size - 1);
         room = size - pos;
         if (r.opcode == OP_SET)
            len = $urandom_range((room < 24) ? room : 24);
         else if (r.opcode == OP_CLEAR)
            len = $urandom_range((room < 12) ? room : 12);
         else if (r.opcode == OP_FIND)
            len = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(1, size);
      end
      r.position   = POSITION_W'(pos);
      r.run_length = LENGTH_W'(len);
      return r;
   endfunction

   // present one request word, called and left at a falling edge
   task automatic send_request(input req_type r);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if ($urandom_range(99) < send_idle_pct / 6) gap += $urandom_range(1, 300);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // write the size register once nothing is in flight
   task automatic write_size(input int unsigned value);
      start <= 1'b0;
      do @(posedge clock); while (tracker.expected_rsp.size() != 0 || busy);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= CSR_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_size = (value > MAP_BITS) ? MAP_BITS : value;
   endtask

   initial begin
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      reset     = 1'b1;
      tracker   = new();
      cur_size  = MAP_BITS;
      send_idle_pct = 18;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full map, edges of position and length
      send_request(mk_req(OP_TEST, 0, 0));
      send_request(mk_req(OP_TEST, 255, 511));
      send_request(mk_req(OP_FIND, 0, 0));
      send_request(mk_req(OP_FIND, 0, 256));
      send_request(mk_req(OP_FIND, 0, 257));
      send_request(mk_req(OP_SET, 0, 256));
      send_request(mk_req(OP_TEST, 100, 0));
      send_request(mk_req(OP_FIND, 0, 1));
      send_request(mk_req(OP_CLEAR, 10, 5));
      send_request(mk_req(OP_FIND, 0, 5));
      send_request(mk_req(OP_FIND, 0, 6));
      send_request(mk_req(OP_SET, 255, 2));
      send_request(mk_req(OP_CLEAR, 255, 1));
      send_request(mk_req(OP_TEST, 255, 0));
      send_request(mk_req(OP_SET, 200, 0));
      send_request(mk_req(OP_CLEAR, 0, 511));
      send_request(mk_req(OP_CLEAR, 0, 256));

      // empty map, then size above the map, then a single bit
      write_size(0);
      send_request(mk_req(OP_TEST, 0, 0));
      send_request(mk_req(OP_SET, 0, 0));
      send_request(mk_req(OP_CLEAR, 1, 0));
      send_request(mk_req(OP_FIND, 0, 1));
      write_size(511);
      send_request(mk_req(OP_FIND, 255, 256));
      write_size(1);
      send_request(mk_req(OP_SET, 0, 1));
      send_request(mk_req(OP_TEST, 0, 0));
      send_request(mk_req(OP_FIND, 0, 1));
      send_request(mk_req(OP_TEST, 1, 0));

      // random: three idle profiles, four sizes each
      size_plan = '{256, 37, 511, 0, 1, 255, 0, 256, 8, 0, 130, 256};
      size_plan[6] = $urandom_range(511);
      size_plan[9] = $urandom_range(2, 255);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 61 : 0;
         for (int s = 0; s < 4; s++) begin
            write_size(size_plan[phase * 4 + s]);
            repeat (RANDOM_ITEMS) send_request(random_req(cur_size));
         end
      end

      // drain
      start <= 1'b0;
      do @(posedge clock); while (tracker.expected_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d responses checked, %0d size writes",
               tracker.noted, tracker.checked, size_writes);
      $display("statuses: %0d ok, %0d out of range, %0d not found; %0d mismatches",
               tracker.status_count[ST_OK], tracker.status_count[ST_RANGE],
               tracker.status_count[ST_NOTFOUND], tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### bitmap_first_fit_allocator_unit.f
rtl/bfa_pkg.sv
rtl/bfa_cell.sv
rtl/bitmap_first_fit_allocator_unit.sv
test/tb_bitmap_first_fit_allocator_unit.sv
